// ===== src/dds_pkg.sv =====
// Shared types and constants for the decimal digit display sequencer.
package dds_pkg;

   localparam int MAX_DIGITS = 16;
   localparam int VALUE_W    = 31;
   localparam int BCD_DIGITS = 10;
   localparam int COUNT_W    = 5;
   localparam int PLACE_W    = 4;
   localparam int BIT_CNT_W  = 5;
   localparam int COORD_W    = 16;
   localparam int STEP_W     = 10;
   localparam int GLYPH_W    = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_X       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_Y       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHOW_PADDING = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIGIT_COUNT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DIGIT_WIDTH  = 3'd4;

   localparam logic [GLYPH_W-1:0] GLYPH_MAX = 4'd9;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } seq_state_type;

   // Double-dabble correction of one BCD digit before the shift.
   function automatic logic [GLYPH_W-1:0] bcd_adjust(input logic [GLYPH_W-1:0] d);
      bcd_adjust = (d >= 4'd5) ? d + 4'd3 : d;
   endfunction

endpackage

// ===== src/decimal_digit_display_sequencer_core.sv =====
// Top level of the decimal digit display sequencer: bit-serial conversion and slot emission.
//
// Each accepted value is converted to decimal by a bit-serial double-dabble
// converter that shifts one binary bit into a ten-digit BCD register per
// clock, MSB first, through every value bit whatever the value. The sequencer
// then emits exactly digit_count slots (saturated at 16), left to right, one
// per cycle while the result side does not stall; pos_x steps by digit_width
// from base_x with 16-bit wrap, and slots left of the most significant digit
// are padding zeros, visible only when show_padding is set. The input is
// stalled from acceptance until the last slot has been loaded into the output
// register, and a digit_count of zero leaves the block idle, with the value
// taken and no result transactions. Configuration writes are always ready and
// must be made only while the block is idle.
module decimal_digit_display_sequencer_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [dds_pkg::VALUE_W-1:0]           req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [dds_pkg::GLYPH_W-1:0]           rsp_glyph,
   output logic signed [dds_pkg::COORD_W-1:0]    rsp_pos_x,
   output logic signed [dds_pkg::COORD_W-1:0]    rsp_pos_y,
   output logic                                  rsp_visible,
   output logic                                  rsp_last,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [dds_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [dds_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   // Configuration registers.
   logic [dds_pkg::COORD_W-1:0] base_x_ff;
   logic [dds_pkg::COORD_W-1:0] base_y_ff;
   logic                        show_padding_ff;
   logic [dds_pkg::COUNT_W-1:0] digit_count_ff;
   logic [dds_pkg::STEP_W-1:0]  digit_width_ff;

   // Sequencer state and datapath.
   dds_pkg::seq_state_type       state_ff, state_in;
   logic [dds_pkg::VALUE_W-1:0]   bin_ff, bin_in;
   logic [dds_pkg::GLYPH_W-1:0]   bcd_ff [dds_pkg::BCD_DIGITS];
   logic [dds_pkg::GLYPH_W-1:0]   bcd_in [dds_pkg::BCD_DIGITS];
   logic [dds_pkg::GLYPH_W-1:0]   bcd_adj [dds_pkg::BCD_DIGITS];
   logic [dds_pkg::BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [dds_pkg::PLACE_W-1:0]   place_ff, place_in;
   logic                          seen_ff, seen_in;
   logic [dds_pkg::COORD_W-1:0]   pos_acc_ff, pos_acc_in;

   // Output register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [dds_pkg::GLYPH_W-1:0]   rsp_glyph_ff, rsp_glyph_in;
   logic [dds_pkg::COORD_W-1:0]   rsp_pos_x_ff, rsp_pos_x_in;
   logic                          rsp_visible_ff, rsp_visible_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic [dds_pkg::COUNT_W-1:0]   slot_count;
   logic                          req_take;
   logic                          out_free;
   logic [dds_pkg::GLYPH_W-1:0]   cur_digit;
   logic                          in_number;

   // A digit count above the slot limit saturates.
   assign slot_count = (digit_count_ff > dds_pkg::COUNT_W'(dds_pkg::MAX_DIGITS))
                       ? dds_pkg::COUNT_W'(dds_pkg::MAX_DIGITS) : digit_count_ff;

   assign req_stall = (state_ff != dds_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Places above the converter's ten digits always read as zero.
   assign cur_digit = (place_ff < dds_pkg::PLACE_W'(dds_pkg::BCD_DIGITS))
                      ? bcd_ff[place_ff] : '0;
   // The units place is part of the number even for value zero.
   assign in_number = seen_ff || (cur_digit != '0) || (place_ff == '0);

   always_comb begin
      for (int i = 0; i < dds_pkg::BCD_DIGITS; i++) begin
         bcd_adj[i] = dds_pkg::bcd_adjust(bcd_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_x_ff       <= '0;
         base_y_ff       <= '0;
         show_padding_ff <= 1'b1;
         digit_count_ff  <= '0;
         digit_width_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            dds_pkg::CSR_BASE_X:       base_x_ff       <= csr_wdata;
            dds_pkg::CSR_BASE_Y:       base_y_ff       <= csr_wdata;
            dds_pkg::CSR_SHOW_PADDING: show_padding_ff <= csr_wdata[0];
            dds_pkg::CSR_DIGIT_COUNT:  digit_count_ff  <= csr_wdata[dds_pkg::COUNT_W-1:0];
            dds_pkg::CSR_DIGIT_WIDTH:  digit_width_ff  <= csr_wdata[dds_pkg::STEP_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dds_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff         <= bin_in;
      bcd_ff         <= bcd_in;
      bit_cnt_ff     <= bit_cnt_in;
      place_ff       <= place_in;
      seen_ff        <= seen_in;
      pos_acc_ff     <= pos_acc_in;
      rsp_glyph_ff   <= rsp_glyph_in;
      rsp_pos_x_ff   <= rsp_pos_x_in;
      rsp_visible_ff <= rsp_visible_in;
      rsp_last_ff    <= rsp_last_in;
   end

   always_comb begin
      state_in       = state_ff;
      bin_in         = bin_ff;
      bcd_in         = bcd_ff;
      bit_cnt_in     = bit_cnt_ff;
      place_in       = place_ff;
      seen_in        = seen_ff;
      pos_acc_in     = pos_acc_ff;
      rsp_glyph_in   = rsp_glyph_ff;
      rsp_pos_x_in   = rsp_pos_x_ff;
      rsp_visible_in = rsp_visible_ff;
      rsp_last_in    = rsp_last_ff;
      // A waiting result leaves the output register once the consumer takes it.
      rsp_valid_in   = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         dds_pkg::ST_IDLE: begin
            if (req_take && (slot_count != '0)) begin
               bin_in     = req_value;
               for (int i = 0; i < dds_pkg::BCD_DIGITS; i++) begin
                  bcd_in[i] = '0;
               end
               bit_cnt_in = dds_pkg::BIT_CNT_W'(dds_pkg::VALUE_W - 1);
               place_in   = dds_pkg::PLACE_W'(slot_count - 1'b1);
               seen_in    = 1'b0;
               pos_acc_in = base_x_ff;
               state_in   = dds_pkg::ST_CONVERT;
            end
         end
         dds_pkg::ST_CONVERT: begin
            // One binary bit enters the BCD register per cycle, MSB first.
            bcd_in[0] = {bcd_adj[0][dds_pkg::GLYPH_W-2:0], bin_ff[dds_pkg::VALUE_W-1]};
            for (int i = 1; i < dds_pkg::BCD_DIGITS; i++) begin
               bcd_in[i] = {bcd_adj[i][dds_pkg::GLYPH_W-2:0],
                            bcd_adj[i-1][dds_pkg::GLYPH_W-1]};
            end
            bin_in     = {bin_ff[dds_pkg::VALUE_W-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - 1'b1;
            if (bit_cnt_ff == '0) begin
               // When the number is wider than the row, a nonzero digit cut
               // off on the left makes every shown slot a real digit.
               for (int i = 0; i < dds_pkg::BCD_DIGITS; i++) begin
                  if ((dds_pkg::PLACE_W'(i) > place_ff) && (bcd_in[i] != '0)) begin
                     seen_in = 1'b1;
                  end
               end
               state_in = dds_pkg::ST_EMIT;
            end
         end
         dds_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_glyph_in   = cur_digit;
               rsp_pos_x_in   = pos_acc_ff;
               rsp_visible_in = in_number || show_padding_ff;
               rsp_last_in    = (place_ff == '0);
               seen_in        = in_number;
               pos_acc_in     = pos_acc_ff + dds_pkg::COORD_W'(digit_width_ff);
               place_in       = place_ff - 1'b1;
               if (place_ff == '0) begin
                  state_in = dds_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = dds_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_glyph   = rsp_glyph_ff;
   assign rsp_pos_x   = rsp_pos_x_ff;
   assign rsp_pos_y   = base_y_ff;
   assign rsp_visible = rsp_visible_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

// ===== src/dds_checker.sv =====
// Port-level checker for the decimal digit display sequencer and its bind.
module dds_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [dds_pkg::GLYPH_W-1:0]         rsp_glyph,
   input logic signed [dds_pkg::COORD_W-1:0]  rsp_pos_x,
   input logic                                rsp_visible,
   input logic                                rsp_last
);

   // A stalled result transaction holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_glyph) && $stable(rsp_pos_x)
                                  && $stable(rsp_last))
      else $error("stalled result changed");

   // While a row is unfinished the input side stays stalled.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("input accepted in the middle of a row");

   // The next slot of a row follows the previous one without a gap.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid)
      else $error("gap inside a row");

   // Glyphs are decimal, and blank slots are padding zeros.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_glyph <= dds_pkg::GLYPH_MAX) && (rsp_visible || rsp_glyph == '0))
      else $error("bad glyph");

endmodule

bind decimal_digit_display_sequencer_core dds_checker u_dds_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_glyph   (rsp_glyph),
   .rsp_pos_x   (rsp_pos_x),
   .rsp_visible (rsp_visible),
   .rsp_last    (rsp_last)
);

// ===== dv/decimal_digit_display_sequencer_core_tb.sv =====
// Self-checking testbench for the decimal digit display sequencer core.
`timescale 1ns / 100ps

// Each number sent to the block turns into a row of digit draw slots. The
// bench keeps its own copy of the five display registers and predicts every
// slot (glyph, x, y, visibility, last flag) when a number transaction is
// accepted. The monitor compares each accepted slot transaction, field by
// field, with the oldest prediction.
//
// The run has two parts. The first part is a table of directed rows. It
// covers register writes at their extremes, zero and saturated digit counts,
// value zero, truncation of long values, x wrap and writes to unmapped
// register indexes. Rows where the answer is obvious carry a typed-in slot.
// The random part that follows runs in phases. Each phase waits for the block
// to empty, reprograms every register and then streams numbers with random
// gaps, while the result side stalls in random bursts. One phase holds the
// result side off for a long stretch so that the block backs up and stalls
// its input. The tail of the run keeps the last setup and has no idling on
// either side.
module decimal_digit_display_sequencer_core_tb;

   localparam int CLK_PERIOD     = 12;
   localparam int RESET_CYCLES   = 12;
   localparam int SETTLE_CYCLES  = 64;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 160;
   localparam int QUIET_ITEMS    = 24;
   localparam int HOLD_PHASE     = 2;
   localparam int REPORT_LIMIT   = 10;

   // Register indexes past the last mapped one. Writes to them are ignored.
   localparam logic [dds_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd5;
   localparam logic [dds_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [dds_pkg::GLYPH_W-1:0]        glyph;
      logic signed [dds_pkg::COORD_W-1:0] pos_x;
      logic signed [dds_pkg::COORD_W-1:0] pos_y;
      logic                               visible;
      logic                               last;
   } draw_slot_type;

   // Kinds of directed rows: a register write, a number checked against the
   // predictor, a number that must produce nothing, and a number whose single
   // slot is typed into the table.
   typedef enum logic [1:0] {
      ROW_WRITE,
      ROW_NUMBER,
      ROW_NUMBER_SILENT,
      ROW_NUMBER_ONE
   } row_kind_type;

   typedef struct packed {
      row_kind_type                     kind;
      logic [dds_pkg::CSR_IDX_W-1:0]    index;
      logic [dds_pkg::CSR_DATA_W-1:0]   data;
      logic [dds_pkg::VALUE_W-1:0]      value;
      draw_slot_type                    golden;
   } dir_row_type;

   localparam draw_slot_type NO_SLOT = '0;
   localparam int DIRECTED_LEN = 29;

   // Typed-in slots are only used while one slot sits at x = 0, y = 0.
   localparam dir_row_type DIRECTED_ROWS [DIRECTED_LEN] = '{
      // Out of reset the digit count is zero, so nothing comes back.
      '{ROW_NUMBER_SILENT, '0, '0, 31'd5, NO_SLOT},
      '{ROW_WRITE, dds_pkg::CSR_DIGIT_COUNT, 16'h0001, '0, NO_SLOT},
      '{ROW_NUMBER_ONE, '0, '0, 31'd0, '{4'd0, 16'sd0, 16'sd0, 1'b1, 1'b1}},
      '{ROW_NUMBER_ONE, '0, '0, 31'd7, '{4'd7, 16'sd0, 16'sd0, 1'b1, 1'b1}},
      // Only the units digit of the largest value fits in one slot.
      '{ROW_NUMBER_ONE, '0, '0, 31'h7FFF_FFFF, '{4'd7, 16'sd0, 16'sd0, 1'b1, 1'b1}},
      '{ROW_NUMBER_ONE, '0, '0, 31'd1000000000, '{4'd0, 16'sd0, 16'sd0, 1'b1, 1'b1}},
      // With padding off, a lone zero is still a real digit and stays visible.
      '{ROW_WRITE, dds_pkg::CSR_SHOW_PADDING, 16'h0000, '0, NO_SLOT},
      '{ROW_NUMBER_ONE, '0, '0, 31'd0, '{4'd0, 16'sd0, 16'sd0, 1'b1, 1'b1}},
      '{ROW_WRITE, dds_pkg::CSR_BASE_X, 16'h8000, '0, NO_SLOT},
      '{ROW_WRITE, dds_pkg::CSR_BASE_Y, 16'h7FFF, '0, NO_SLOT},
      '{ROW_WRITE, dds_pkg::CSR_DIGIT_WIDTH, 16'hFFFF, '0, NO_SLOT},
      '{ROW_WRITE, dds_pkg::CSR_DIGIT_COUNT, 16'h0010, '0, NO_SLOT},
      '{ROW_NUMBER, '0, '0, 31'd0, NO_SLOT},
      '{ROW_NUMBER, '0, '0, 31'h7FFF_FFFF, NO_SLOT},
      '{ROW_NUMBER, '0, '0, 31'd1234, NO_SLOT},
      '{ROW_WRITE, dds_pkg::CSR_SHOW_PADDING, 16'hFFFF, '0, NO_SLOT},
      '{ROW_NUMBER, '0, '0, 31'd1234, NO_SLOT},
      // A count of 31 saturates at the maximum number of slots.
      '{ROW_WRITE, dds_pkg::CSR_DIGIT_COUNT, 16'h001F, '0, NO_SLOT},
      '{ROW_NUMBER, '0, '0, 31'd9, NO_SLOT},
      '{ROW_WRITE, CSR_SPARE_LO, 16'hFFFF, '0, NO_SLOT},
      '{ROW_WRITE, CSR_SPARE_HI, 16'h0000, '0, NO_SLOT},
      '{ROW_NUMBER, '0, '0, 31'd1000000000, NO_SLOT},
      // Three slots starting at the right edge of x wrap around.
      '{ROW_WRITE, dds_pkg::CSR_BASE_X, 16'h7FFF, '0, NO_SLOT},
      '{ROW_WRITE, dds_pkg::CSR_DIGIT_WIDTH, 16'h0001, '0, NO_SLOT},
      '{ROW_WRITE, dds_pkg::CSR_DIGIT_COUNT, 16'h0003, '0, NO_SLOT},
      '{ROW_NUMBER, '0, '0, 31'd999, NO_SLOT},
      '{ROW_NUMBER, '0, '0, 31'd1000, NO_SLOT},
      // Upper data bits beyond the count field are dropped, leaving zero.
      '{ROW_WRITE, dds_pkg::CSR_DIGIT_COUNT, 16'hFFE0, '0, NO_SLOT},
      '{ROW_NUMBER_SILENT, '0, '0, 31'd123, NO_SLOT}
   };

   logic                                 clock = 1'b0;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_stall;
   logic [dds_pkg::VALUE_W-1:0]          req_value;
   logic                                 rsp_valid;
   logic                                 rsp_stall;
   logic [dds_pkg::GLYPH_W-1:0]          rsp_glyph;
   logic signed [dds_pkg::COORD_W-1:0]   rsp_pos_x;
   logic signed [dds_pkg::COORD_W-1:0]   rsp_pos_y;
   logic                                 rsp_visible;
   logic                                 rsp_last;
   logic                                 csr_valid;
   logic                                 csr_ready;
   logic [dds_pkg::CSR_IDX_W-1:0]        csr_index;
   logic [dds_pkg::CSR_DATA_W-1:0]       csr_wdata;

   // The bench's own copy of the display registers, at their reset values.
   logic [dds_pkg::COORD_W-1:0]          shadow_base_x  = '0;
   logic [dds_pkg::COORD_W-1:0]          shadow_base_y  = '0;
   logic                                 shadow_padding = 1'b1;
   logic [dds_pkg::COUNT_W-1:0]          shadow_count   = '0;
   logic [dds_pkg::STEP_W-1:0]           shadow_width   = '0;

   draw_slot_type               expected_slots [$];
   draw_slot_type               seen_slot;
   draw_slot_type               want_slot;

   int                          mismatches   = 0;
   int                          idle_cycles  = 0;
   int                          n_values     = 0;
   int                          n_slots      = 0;
   int                          n_writes     = 0;
   bit                          hold_request = 1'b0;
   bit                          quiet_tail   = 1'b0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   decimal_digit_display_sequencer_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_value   (req_value),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_glyph   (rsp_glyph),
      .rsp_pos_x   (rsp_pos_x),
      .rsp_pos_y   (rsp_pos_y),
      .rsp_visible (rsp_visible),
      .rsp_last    (rsp_last),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // Works out the row of slots for one number under the current register
   // copy. Slots left of the most significant digit are padding zeros, and a
   // count above the maximum is clipped to it.
   function automatic void queue_digit_row(input logic [dds_pkg::VALUE_W-1:0] value);
      int unsigned                 rest;
      int unsigned                 ndigits;
      int unsigned                 slots;
      int unsigned                 place;
      logic [dds_pkg::GLYPH_W-1:0] digit [dds_pkg::BCD_DIGITS];
      draw_slot_type               s;
      rest    = value;
      ndigits = 0;
      // Value zero still has one digit.
      do begin
         digit[ndigits] = dds_pkg::GLYPH_W'(rest % 10);
         rest           = rest / 10;
         ndigits++;
      end while (rest != 0);
      slots = (shadow_count > dds_pkg::MAX_DIGITS) ? dds_pkg::MAX_DIGITS : shadow_count;
      for (int k = 0; k < slots; k++) begin
         place = slots - 1 - k;
         if (place < ndigits) begin
            s.glyph   = digit[place];
            s.visible = 1'b1;
         end else begin
            s.glyph   = '0;
            s.visible = shadow_padding;
         end
         // x keeps only the low 16 bits of the sum.
         s.pos_x = shadow_base_x + dds_pkg::COORD_W'(k * shadow_width);
         s.pos_y = shadow_base_y;
         s.last  = (k == slots - 1);
         expected_slots.push_back(s);
      end
   endfunction

   // Mixes small values, powers of ten and their neighbors, the maximum and
   // full-width random values so that every value bit toggles.
   function automatic logic [dds_pkg::VALUE_W-1:0] pick_value();
      int unsigned p;
      int unsigned k;
      p = 1;
      case ($urandom_range(0, 6))
         0: return dds_pkg::VALUE_W'($urandom_range(0, 9));
         1: begin
            k = $urandom_range(1, 9);
            repeat (k) p = p * 10;
            return dds_pkg::VALUE_W'($urandom_range(0, 1) ? p : p - 1);
         end
         2: return dds_pkg::VALUE_W'($urandom_range(0, 99999));
         3: return {dds_pkg::VALUE_W{1'b1}};
         default: return dds_pkg::VALUE_W'($urandom);
      endcase
   endfunction

   // Offers one number and waits for its transaction. The prediction is made
   // once the block has taken it.
   task automatic send_number(input logic [dds_pkg::VALUE_W-1:0] value, input bit predict);
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      n_values++;
      if (predict) queue_digit_row(value);
   endtask

   task automatic pause_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Leaves csr_valid high; the caller lowers it after the last write of a
   // batch so that back-to-back writes never toggle it within one step.
   task automatic write_register(input logic [dds_pkg::CSR_IDX_W-1:0] index,
                                 input logic [dds_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      n_writes++;
      case (index)
         dds_pkg::CSR_BASE_X:       shadow_base_x  = data;
         dds_pkg::CSR_BASE_Y:       shadow_base_y  = data;
         dds_pkg::CSR_SHOW_PADDING: shadow_padding = data[0];
         dds_pkg::CSR_DIGIT_COUNT:  shadow_count   = data[dds_pkg::COUNT_W-1:0];
         dds_pkg::CSR_DIGIT_WIDTH:  shadow_width   = data[dds_pkg::STEP_W-1:0];
         default: ;
      endcase
   endtask

   // Stops offering numbers until every predicted slot has arrived, then lets
   // the block finish any number that produces no slots.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (expected_slots.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Reprograms all five registers with random data, biased toward the
   // extremes. Upper data bits are random so that masking is exercised.
   task automatic program_random_setup(input bit full_row);
      logic [dds_pkg::CSR_DATA_W-1:0] data;
      data = dds_pkg::CSR_DATA_W'($urandom);
      case ($urandom_range(0, 5))
         0: data = 16'h8000;
         1: data = 16'h7FFF;
         2: data = 16'h0000;
         default: ;
      endcase
      write_register(dds_pkg::CSR_BASE_X, data);
      data = dds_pkg::CSR_DATA_W'($urandom);
      if ($urandom_range(0, 3) == 0) data = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      write_register(dds_pkg::CSR_BASE_Y, data);
      write_register(dds_pkg::CSR_SHOW_PADDING, dds_pkg::CSR_DATA_W'($urandom));
      data = dds_pkg::CSR_DATA_W'($urandom);
      case ($urandom_range(0, 9))
         0: data[dds_pkg::COUNT_W-1:0] = '0;
         1: data[dds_pkg::COUNT_W-1:0] = dds_pkg::COUNT_W'(dds_pkg::MAX_DIGITS);
         2: data[dds_pkg::COUNT_W-1:0] =
               dds_pkg::COUNT_W'($urandom_range(dds_pkg::MAX_DIGITS + 1, 31));
         default: data[dds_pkg::COUNT_W-1:0] =
               dds_pkg::COUNT_W'($urandom_range(1, dds_pkg::MAX_DIGITS));
      endcase
      if (full_row) data[dds_pkg::COUNT_W-1:0] = dds_pkg::COUNT_W'(dds_pkg::MAX_DIGITS);
      write_register(dds_pkg::CSR_DIGIT_COUNT, data);
      data = dds_pkg::CSR_DATA_W'($urandom);
      case ($urandom_range(0, 5))
         0: data[dds_pkg::STEP_W-1:0] = {dds_pkg::STEP_W{1'b1}};
         1: data[dds_pkg::STEP_W-1:0] = '0;
         default: ;
      endcase
      write_register(dds_pkg::CSR_DIGIT_WIDTH, data);
      if ($urandom_range(0, 3) == 0)
         write_register(dds_pkg::CSR_IDX_W'($urandom_range(CSR_SPARE_LO, CSR_SPARE_HI)),
                        dds_pkg::CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   task automatic report_slot_error(input string why, input draw_slot_type want,
                                    input draw_slot_type seen);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("%0t: %s", $realtime, why);
         $display("   expected glyph %0d x %0d y %0d visible %0b last %0b",
                  want.glyph, want.pos_x, want.pos_y, want.visible, want.last);
         $display("   actual   glyph %0d x %0d y %0d visible %0b last %0b",
                  seen.glyph, seen.pos_x, seen.pos_y, seen.visible, seen.last);
      end
   endtask

   // Monitor: counts idle cycles for the watchdog and checks every slot
   // transaction against the oldest prediction. Values are sampled at the
   // edge, before any nonblocking update of that edge takes effect.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            n_slots++;
            seen_slot = '{rsp_glyph, rsp_pos_x, rsp_pos_y, rsp_visible, rsp_last};
            if (expected_slots.size() == 0) begin
               report_slot_error("slot transaction with no slot expected", NO_SLOT,
                                 seen_slot);
            end else begin
               want_slot = expected_slots.pop_front();
               if (seen_slot.glyph !== want_slot.glyph ||
                   seen_slot.pos_x !== want_slot.pos_x ||
                   seen_slot.pos_y !== want_slot.pos_y ||
                   seen_slot.visible !== want_slot.visible ||
                   seen_slot.last !== want_slot.last)
                  report_slot_error("slot field mismatch", want_slot, seen_slot);
            end
         end
      end
   end

   // Result side: random stall bursts and stretches with no stall, one long
   // hold-off on request, and no stalling at all in the tail of the run.
   initial begin
      rsp_stall <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (hold_request) begin
            // Counted here so that the block backs up while numbers keep coming.
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (quiet_tail) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
   end

   // Watchdog: ends the run when no transaction of any kind happens for too
   // long, which covers a hung input, a lost slot and a stuck register port.
   initial begin
      wait (reset === 1'b0);
      do @(posedge clock); while (idle_cycles < WATCHDOG_LIMIT);
      $display("Watchdog: no transaction in %0d cycles, %0d slots outstanding",
               WATCHDOG_LIMIT, expected_slots.size());
      $display("Mismatches found");
      $finish;
   end

   // Sender: directed table first, then random phases.
   initial begin
      bit in_writes;
      int sent;
      int phase;
      int phase_items;
      in_writes = 1'b0;
      sent      = 0;
      phase     = 0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_value <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         if (DIRECTED_ROWS[i].kind == ROW_WRITE) begin
            // Registers change only once the block has gone quiet.
            if (!in_writes) wait_until_drained();
            write_register(DIRECTED_ROWS[i].index, DIRECTED_ROWS[i].data);
            in_writes = 1'b1;
         end else begin
            if (in_writes) csr_valid <= 1'b0;
            in_writes = 1'b0;
            send_number(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].kind == ROW_NUMBER);
            if (DIRECTED_ROWS[i].kind == ROW_NUMBER_ONE)
               expected_slots.push_back(DIRECTED_ROWS[i].golden);
         end
      end
      if (in_writes) csr_valid <= 1'b0;

      while (sent < RANDOM_ITEMS) begin
         // The sender pauses here until every predicted slot has come back.
         // The tail keeps the current setup so that numbers flow without gaps.
         if (!quiet_tail) begin
            wait_until_drained();
            program_random_setup(phase == HOLD_PHASE);
            if (phase == HOLD_PHASE) hold_request = 1'b1;
         end
         phase_items = $urandom_range(6, 18);
         for (int i = 0; i < phase_items && sent < RANDOM_ITEMS; i++) begin
            if (!quiet_tail && !hold_request && $urandom_range(0, 3) == 0)
               pause_sender($urandom_range(1, 15));
            send_number(pick_value(), 1'b1);
            sent++;
            if (sent >= RANDOM_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
         end
         phase++;
      end

      wait_until_drained();
      mismatches += expected_slots.size();
      $display("Sent %0d numbers, compared %0d slot transactions, made %0d register writes.",
               n_values, n_slots, n_writes);
      $display("Covered zero and saturated digit counts, padding on and off, x wrap, backpressure.");
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ===== sim.f =====
src/dds_pkg.sv
src/decimal_digit_display_sequencer_core.sv
src/dds_checker.sv
dv/decimal_digit_display_sequencer_core_tb.sv
